/* rtl/dds_pkg.sv */
package dds_pkg;

    // Table and accumulator geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int QTR_N           = 1 << QTR_BITS;
    localparam int QTR_IDX_W       = QTR_BITS + 1;

    // Fixed-point constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [15:0] WAVE_POS_FULL = 16'sd32767;
    localparam logic signed [15:0] WAVE_NEG_FULL = -16'sd32767;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Waveform shape codes
    localparam logic [2:0] SHAPE_SINE     = 3'd0;
    localparam logic [2:0] SHAPE_SQUARE   = 3'd1;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd2;
    localparam logic [2:0] SHAPE_SAWTOOTH = 3'd3;
    localparam logic [2:0] SHAPE_PULSE    = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_PHASE_STEP     = 3'd0;
    localparam logic [2:0] REG_WAVE_SHAPE     = 3'd1;
    localparam logic [2:0] REG_DUTY_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_GAIN           = 3'd3;
    localparam logic [2:0] REG_DC_OFFSET      = 3'd4;

    // Configuration reset values
    localparam logic [31:0] DUTY_RESET = 32'h8000_0000;
    localparam logic [15:0] GAIN_RESET = 16'h8000;

    typedef struct packed {
        logic        operation;
        logic [31:0] start_phase;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [31:0]        phase_now;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic [2:0]         wave_shape;
        logic [31:0]        duty_threshold;
        logic [15:0]        gain;
        logic signed [15:0] dc_offset;
    } dds_cfg_t;

    typedef logic [15:0] quarter_tab_t [QTR_N + 1];

    // Long division by shift and subtract; only used while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine table, built at elaboration with a Taylor series in Q2.30.
    function automatic quarter_tab_t build_quarter_tab();
        quarter_tab_t      tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   r;
        longint            sum;
        longint unsigned   n;
        logic              neg;
        for (int k = 0; k <= QTR_N; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k)) >> QTR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = 0;
            n    = 1;
            neg  = 1'b0;
            for (int i = 0; i < 20; i++)
            begin
                if (term != 0)
                begin
                    sum  = neg ? sum - longint'(term) : sum + longint'(term);
                    term = udiv64((term * x2) >> 30, (n + 1) * (n + 2));
                    n    = n + 2;
                    neg  = !neg;
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            r = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
            if (r > 32767)
            begin
                r = 32767;
            end
            tab[k] = r[15:0];
        end
        return tab;
    endfunction

    localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();

    // A 32-bit cycle fraction aligned to the top of the accumulator.
    function automatic logic [PHASE_BITS-1:0] to_acc(input logic [31:0] f);
        logic [PHASE_BITS+31:0] tmp;
        tmp = {f, {PHASE_BITS{1'b0}}};
        return tmp[PHASE_BITS+31 -: PHASE_BITS];
    endfunction

    // The top 32 bits of the accumulator as a cycle fraction.
    function automatic logic [31:0] to_frac(input logic [PHASE_BITS-1:0] a);
        logic [PHASE_BITS+31:0] tmp;
        tmp = {a, 32'h0};
        return tmp[PHASE_BITS+31 -: 32];
    endfunction

endpackage

/* rtl/dds_cfg_regs.sv */
module dds_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output dds_pkg::dds_cfg_t     cfg
);
    import dds_pkg::*;

    dds_cfg_t cfg_reg;
    dds_cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register file write decode; unknown indexes change nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:     cfg_next.phase_step     = cfg_data;
                REG_WAVE_SHAPE:     cfg_next.wave_shape     = cfg_data[2:0];
                REG_DUTY_THRESHOLD: cfg_next.duty_threshold = cfg_data;
                REG_GAIN:           cfg_next.gain           = cfg_data[15:0];
                REG_DC_OFFSET:      cfg_next.dc_offset      = $signed(cfg_data[15:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step     <= '0;
            cfg_reg.wave_shape     <= SHAPE_SINE;
            cfg_reg.duty_threshold <= DUTY_RESET;
            cfg_reg.gain           <= GAIN_RESET;
            cfg_reg.dc_offset      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/dds_wave.sv */
module dds_wave (
    input  logic [31:0]        phase,
    input  logic [2:0]         wave_shape,
    input  logic [31:0]        duty_threshold,
    output logic signed [15:0] wave
);
    import dds_pkg::*;

    logic [1:0]            quad;
    logic [QTR_IDX_W-1:0]  idx;
    logic [QTR_IDX_W-1:0]  mirror_idx;
    logic signed [15:0]    tab_fwd;
    logic signed [15:0]    tab_rev;
    logic signed [15:0]    sine_val;
    logic [33:0]           x4;
    logic [33:0]           x2;
    logic [48:0]           prod4;
    logic [48:0]           prod2;
    logic [16:0]           ramp4;
    logic [16:0]           ramp2;
    logic signed [17:0]    tri_val;
    logic signed [17:0]    saw_val;

    // Quarter-wave lookup, mirrored and negated per quadrant.
    assign quad       = phase[31:30];
    assign idx        = {1'b0, phase[29 -: QTR_BITS]};
    assign mirror_idx = QTR_IDX_W'(QTR_N) - idx;
    assign tab_fwd    = $signed(QUARTER_TAB[idx]);
    assign tab_rev    = $signed(QUARTER_TAB[mirror_idx]);

    always_comb
    begin
        unique case (quad)
            2'd0:    sine_val = tab_fwd;
            2'd1:    sine_val = tab_rev;
            2'd2:    sine_val = -tab_fwd;
            default: sine_val = -tab_rev;
        endcase
    end

    // Rounded ramps over four and two times the phase.
    assign x4    = {phase, 2'b00};
    assign x2    = {1'b0, phase, 1'b0};
    assign prod4 = 49'(x4) * 49'd32767 + 49'h0_8000_0000;
    assign prod2 = 49'(x2) * 49'd32767 + 49'h0_8000_0000;
    assign ramp4 = prod4[48:32];
    assign ramp2 = prod2[48:32];

    assign tri_val = phase[31] ? 18'sd98301 - $signed({1'b0, ramp4})
                               : $signed({1'b0, ramp4}) - 18'sd32767;
    assign saw_val = $signed({1'b0, ramp2}) - 18'sd32767;

    // Shape select; unused codes give the sine.
    always_comb
    begin
        unique case (wave_shape)
            SHAPE_SQUARE:   wave = phase[31] ? WAVE_NEG_FULL : WAVE_POS_FULL;
            SHAPE_TRIANGLE: wave = tri_val[15:0];
            SHAPE_SAWTOOTH: wave = saw_val[15:0];
            SHAPE_PULSE:    wave = (phase < duty_threshold) ? WAVE_POS_FULL : WAVE_NEG_FULL;
            default:        wave = sine_val;
        endcase
    end

endmodule

/* rtl/dds_scale.sv */
module dds_scale (
    input  logic signed [15:0] wave,
    input  logic [15:0]        gain,
    input  logic signed [15:0] dc_offset,
    output logic signed [15:0] sample
);
    logic signed [32:0] prod;
    logic signed [32:0] rounded;
    logic signed [17:0] scaled;
    logic signed [18:0] sum;

    // Q1.15 gain with round-half-up, floor shift keeps the sign.
    assign prod    = 33'(wave) * 33'($signed({1'b0, gain}));
    assign rounded = prod + 33'sd16384;
    assign scaled  = rounded[32:15];

    // Offset and saturate to 16 bits.
    assign sum = 19'(scaled) + 19'(dc_offset);

    always_comb
    begin
        priority if (sum > 19'sd32767)
        begin
            sample = 16'sh7FFF;
        end
        else if (sum < -19'sd32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = sum[15:0];
        end
    end

endmodule

/* rtl/dds_waveform_generator_top.sv */
// Direct digital synthesis waveform generator.
// A request is registered in the phase capture register when it is accepted, then in the
// result register, from which it is presented.
// Throughput: one request per cycle while the output is not stalled; the capture stage lets
// one more request in while a result waits on the output.
// Reset (rst_n, asynchronous, active low) clears phase and pipeline, loads register defaults.
module dds_waveform_generator_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  dds_pkg::in_item_t     in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output dds_pkg::out_item_t    out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import dds_pkg::*;

    dds_cfg_t              cfg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic                  cap_valid_reg;
    logic                  cap_op_reg;
    logic [31:0]           cap_phase_reg;
    logic [31:0]           cap_phase_now_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  in_take;
    logic                  out_advance;
    logic signed [15:0]    wave;
    logic signed [15:0]    scaled_sample;

    dds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Pipeline flow control.
    assign out_advance = !out_valid_reg || out_ready;
    assign in_ready    = !cap_valid_reg || out_advance;
    assign in_take     = in_valid && in_ready;

    // Phase accumulator: load or advance by the step with natural wrap.
    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        if (in_take)
        begin
            if (in_item.operation == OP_LOAD)
            begin
                phase_acc_next = to_acc(in_item.start_phase);
            end
            else
            begin
                phase_acc_next = phase_acc_reg + to_acc(cfg.phase_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            cap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
            if (in_ready)
            begin
                cap_valid_reg <= in_valid;
            end
            if (out_advance)
            begin
                out_valid_reg <= cap_valid_reg;
            end
        end
    end

    // Capture stage: the phase the sample is taken at and the phase after the request.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cap_op_reg        <= in_item.operation;
            cap_phase_reg     <= to_frac(phase_acc_reg);
            cap_phase_now_reg <= to_frac(phase_acc_next);
        end
    end

    dds_wave u_wave (
        .phase          (cap_phase_reg),
        .wave_shape     (cfg.wave_shape),
        .duty_threshold (cfg.duty_threshold),
        .wave           (wave)
    );

    dds_scale u_scale (
        .wave      (wave),
        .gain      (cfg.gain),
        .dc_offset (cfg.dc_offset),
        .sample    (scaled_sample)
    );

    // Result register; a load request returns a zero sample.
    always_comb
    begin
        out_item_next.sample    = (cap_op_reg == OP_LOAD) ? 16'sd0 : scaled_sample;
        out_item_next.phase_now = cap_phase_now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && cap_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* bench/tb.sv */
module tb;

    // Sine table geometry, kept in step with the block's build.
    localparam int TABLE_BITS = dds_pkg::SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam longint unsigned HALF_PI_Q30 = dds_pkg::HALF_PI_Q30;

    // Shape code with no waveform of its own; the block falls back to sine.
    localparam logic [2:0] SHAPE_SPARE = 3'd7;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    dds_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    dds_pkg::out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Mirror of the generator: phase accumulator and register file.
    logic [31:0] model_phase = '0;
    logic [31:0] model_step = '0;
    logic [2:0] model_shape = dds_pkg::SHAPE_SINE;
    logic [31:0] model_duty = dds_pkg::DUTY_RESET;
    logic [15:0] model_gain = dds_pkg::GAIN_RESET;
    logic signed [15:0] model_offset = '0;
    int sine_quarter [QUARTER + 1];

    dds_pkg::out_item_t pending_samples [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit src_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int sink_hold = 0;

    dds_waveform_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Quarter-wave sine in Q1.15, from a Taylor series evaluated in Q2.30.
    initial
    begin : sine_table_build
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned n;
        longint unsigned r;
        longint sum;
        bit neg;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x = (HALF_PI_Q30 * k) / QUARTER;
            x2 = (x * x) >> 30;
            term = x;
            sum = 0;
            n = 1;
            neg = 1'b0;
            while (term != 0 && n < 40)
            begin
                sum = neg ? sum - longint'(term) : sum + longint'(term);
                term = ((term * x2) >> 30) / ((n + 1) * (n + 2));
                n = n + 2;
                neg = !neg;
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            r = (sum * 32767 + (64'd1 << 29)) >> 30;
            if (r > 32767)
            begin
                r = 32767;
            end
            sine_quarter[k] = int'(r);
        end
    end

    // Rounded Q1.15 ramp of a phase fraction scaled up by 2 or 4.
    function automatic int ramp_q15(longint unsigned x);
        return int'((x * 32767 + 64'h8000_0000) >> 32);
    endfunction

    // Unscaled waveform level at a phase, in Q1.15.
    function automatic int wave_level(logic [31:0] p);
        longint unsigned pw;
        int idx;
        pw = 64'(p);
        case (model_shape)
            dds_pkg::SHAPE_SQUARE:
                return p[31] ? -32767 : 32767;
            dds_pkg::SHAPE_TRIANGLE:
                return p[31] ? 98301 - ramp_q15(pw * 4) : ramp_q15(pw * 4) - 32767;
            dds_pkg::SHAPE_SAWTOOTH:
                return ramp_q15(pw * 2) - 32767;
            dds_pkg::SHAPE_PULSE:
                return (p < model_duty) ? 32767 : -32767;
            default:
            begin
                idx = int'((p >> (32 - TABLE_BITS)) & (QUARTER - 1));
                case (p[31:30])
                    2'd0: return sine_quarter[idx];
                    2'd1: return sine_quarter[QUARTER - idx];
                    2'd2: return -sine_quarter[idx];
                    default: return -sine_quarter[QUARTER - idx];
                endcase
            end
        endcase
    endfunction

    // Gain with rounding, offset, then clamp to the 16-bit output range.
    function automatic logic signed [15:0] output_sample(int level);
        longint acc;
        acc = longint'(level) * longint'(model_gain) + 16384;
        acc = (acc >>> 15) + longint'(model_offset);
        if (acc > 32767)
        begin
            acc = 32767;
        end
        if (acc < -32768)
        begin
            acc = -32768;
        end
        return acc[15:0];
    endfunction

    // Output expected for one request; advances the mirrored accumulator.
    function automatic dds_pkg::out_item_t next_dds_output(dds_pkg::in_item_t req);
        dds_pkg::out_item_t res;
        if (req.operation == dds_pkg::OP_LOAD)
        begin
            model_phase = req.start_phase;
            res.sample = '0;
        end
        else
        begin
            res.sample = output_sample(wave_level(model_phase));
            model_phase = model_phase + model_step;
        end
        res.phase_now = model_phase;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    // Register write; the register file is only touched while the block is idle.
    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            dds_pkg::REG_PHASE_STEP: model_step = data;
            dds_pkg::REG_WAVE_SHAPE: model_shape = data[2:0];
            dds_pkg::REG_DUTY_THRESHOLD: model_duty = data;
            dds_pkg::REG_GAIN: model_gain = data[15:0];
            dds_pkg::REG_DC_OFFSET: model_offset = data[15:0];
            default: ; // indexes past the last register are ignored
        endcase
        @(posedge clk);
    endtask

    // Offer one request, optionally after a random gap, and record its result.
    task automatic send_request(logic op, logic [31:0] phase);
        dds_pkg::in_item_t req;
        int gap;
        req.operation = op;
        req.start_phase = phase;
        gap = (src_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (!in_ready);
        pending_samples.push_back(next_dds_output(req));
    endtask

    // Stop offering and wait until every outstanding result is back.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly ticks, with loads of arbitrary phases mixed in.
    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_request(($urandom_range(0, 9) < 2) ? dds_pkg::OP_LOAD : dds_pkg::OP_TICK,
                         $urandom);
        end
    endtask

    // New register settings, often at their extremes, with junk in the unused bits.
    task automatic write_random_settings;
        logic [31:0] data;
        drain;
        case ($urandom_range(0, 3))
            0: data = 32'h0;
            1: data = 32'hFFFF_FFFF;
            2: data = $urandom_range(1, 32'h0100_0000);
            default: data = $urandom;
        endcase
        write_reg(dds_pkg::REG_PHASE_STEP, data);
        write_reg(dds_pkg::REG_WAVE_SHAPE, $urandom);
        case ($urandom_range(0, 3))
            0: data = 32'h0;
            1: data = 32'hFFFF_FFFF;
            default: data = $urandom;
        endcase
        write_reg(dds_pkg::REG_DUTY_THRESHOLD, data);
        data = $urandom;
        case ($urandom_range(0, 4))
            0: data[15:0] = 16'h0000;
            1: data[15:0] = 16'hFFFF;
            2: data[15:0] = dds_pkg::GAIN_RESET;
            default: ;
        endcase
        write_reg(dds_pkg::REG_GAIN, data);
        data = $urandom;
        case ($urandom_range(0, 4))
            0: data[15:0] = 16'h8000;
            1: data[15:0] = 16'h7FFF;
            2: data[15:0] = 16'h0000;
            default: ;
        endcase
        write_reg(dds_pkg::REG_DC_OFFSET, data);
        write_reg(3'($urandom_range(int'(dds_pkg::REG_DC_OFFSET) + 1,
                                    (1 << $bits(cfg_index)) - 1)), $urandom);
    endtask

    // Behavior straight out of reset: zero step, sine, unity gain.
    task automatic test_reset_defaults;
        send_request(dds_pkg::OP_TICK, $urandom);
        send_request(dds_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_request(dds_pkg::OP_TICK, 32'h0);
        send_request(dds_pkg::OP_LOAD, 32'h4000_0000);
        send_request(dds_pkg::OP_TICK, 32'hFFFF_FFFF);
        drain;
    endtask

    // Each shape across the half-cycle boundary, where most of them switch.
    task automatic test_waveform_shapes;
        logic [2:0] shapes [6];
        shapes = '{dds_pkg::SHAPE_SINE, dds_pkg::SHAPE_SQUARE, dds_pkg::SHAPE_TRIANGLE,
                   dds_pkg::SHAPE_SAWTOOTH, dds_pkg::SHAPE_PULSE, SHAPE_SPARE};
        write_reg(dds_pkg::REG_PHASE_STEP, 32'h1);
        foreach (shapes[i])
        begin
            drain;
            write_reg(dds_pkg::REG_WAVE_SHAPE, 32'(shapes[i]));
            send_request(dds_pkg::OP_LOAD, 32'h7FFF_FFFF);
            send_request(dds_pkg::OP_TICK, 32'h0);
            send_request(dds_pkg::OP_TICK, 32'h0);
        end
        drain;
    endtask

    // Clamping at both rails, pulse duty at its limits, and zero gain.
    task automatic test_saturation;
        write_reg(dds_pkg::REG_GAIN, 32'hFFFF);
        write_reg(dds_pkg::REG_WAVE_SHAPE, 32'(dds_pkg::SHAPE_SQUARE));
        write_reg(dds_pkg::REG_DC_OFFSET, 32'h7FFF);
        send_request(dds_pkg::OP_LOAD, 32'h0);
        send_request(dds_pkg::OP_TICK, 32'h0);
        drain;
        write_reg(dds_pkg::REG_DC_OFFSET, 32'h8000);
        send_request(dds_pkg::OP_LOAD, 32'h8000_0000);
        send_request(dds_pkg::OP_TICK, 32'h0);
        drain;
        write_reg(dds_pkg::REG_WAVE_SHAPE, 32'(dds_pkg::SHAPE_PULSE));
        write_reg(dds_pkg::REG_DUTY_THRESHOLD, 32'h0);
        send_request(dds_pkg::OP_TICK, 32'h0);
        drain;
        write_reg(dds_pkg::REG_DUTY_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(dds_pkg::REG_GAIN, 32'h0);
        send_request(dds_pkg::OP_LOAD, 32'hFFFF_FFFF);
        send_request(dds_pkg::OP_TICK, 32'h0);
        send_request(dds_pkg::OP_TICK, 32'h0);
        drain;
    endtask

    // Random traffic over many register settings, with idling on both sides.
    task automatic test_random_settings;
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        for (int s = 0; s < 20; s++)
        begin
            write_random_settings();
            send_random(55);
        end
        drain;
    endtask

    // Long output stall while requests keep coming, then a full pause.
    task automatic test_backpressure;
        src_gaps = 1'b0;
        sink_hold = 200;
        send_random(60);
        drain;
        src_gaps = 1'b1;
        send_random(40);
        drain;
    endtask

    // Back-to-back traffic with no idling at all.
    task automatic test_full_rate;
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        write_random_settings();
        send_random(100);
        write_random_settings();
        send_random(100);
        drain;
    endtask

    // Output side: random stall bursts, or one long hold when asked for.
    initial
    begin : result_sink
        int stall;
        forever
        begin
            @(posedge clk);
            stall = 0;
            if (sink_hold > 0)
            begin
                stall = sink_hold;
                sink_hold = 0;
            end
            else if (sink_stalls && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 12);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        dds_pkg::out_item_t want;
        if (out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch("result with nothing pending, phase_now",
                                out_item.phase_now, 0);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_item.sample !== want.sample)
                begin
                    report_mismatch("sample", out_item.sample, want.sample);
                end
                if (out_item.phase_now !== want.phase_now)
                begin
                    report_mismatch("phase_now", out_item.phase_now, want.phase_now);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_waveform_shapes();
        test_saturation();
        test_random_settings();
        test_backpressure();
        test_full_rate();
        drain;
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
